FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the terrain height block.
// No dependencies; every macro takes a clock, an active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/thi_pkg.sv
// Shared constants, codes and command struct of the terrain height interpolator.
// No dependencies; imported by every module of the block.
package thi_pkg;

	// Number formats.
	localparam int FRAC_BITS = 8;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int ADDR_W    = 16;              // log2 of the vertex count
	localparam int HGT_W     = 24;
	localparam int POS_W     = 32;
	localparam int OUT_W     = 32;
	localparam int DIM_W     = 9;
	localparam int COORD_W   = 8;
	localparam int CS_W      = 8;
	localparam int PADDR_W   = 4;
	localparam int DATA_W    = 32;

	// Divider: signed numerator, two quotient bits per step.
	localparam int NUM_W     = POS_W + 2;
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = NUM_W / DIV_BITS;
	localparam int QUO_W     = NUM_W + 1;

	// Offsets and the multiply-accumulate unit.
	localparam int DLT_W     = QUO_W + 1;
	localparam int SPLIT     = DLT_W / 2;
	localparam int COEF_W    = HGT_W + 1;
	localparam int HALF_W    = SPLIT + 1;
	localparam int PROD_W    = COEF_W + HALF_W;
	localparam int ACC_W     = 64;

	// Sequencer counter.
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
	localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(4);
	localparam logic [CNT_W-1:0] MAC_LAST  = CNT_W'(4);

	// Grid dimension limits.
	localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(256);

	// Register reset values.
	localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(256);
	localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(256);
	localparam logic [CS_W-1:0]  CS_RST   = CS_W'(10);

	typedef enum logic [1:0] {
		REG_GRID_COLS = 2'd0,
		REG_GRID_ROWS = 2'd1,
		REG_CELL_SIZE = 2'd2
	} reg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CORNER_A = 2'd0,
		CORNER_B = 2'd1,
		CORNER_C = 2'd2,
		CORNER_D = 2'd3
	} corner_t;

	typedef enum logic [1:0] {
		OP_C1_LO = 2'd0,
		OP_C1_HI = 2'd1,
		OP_C2_LO = 2'd2,
		OP_C2_HI = 2'd3
	} mac_op_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic    mem_wr;
		logic    div_load;
		logic    div_step;
		logic    px_load;
		logic    cell_load;
		logic    addr_load;
		logic    rd_en;
		corner_t rd_sel;
		logic    cap_en;
		corner_t cap_sel;
		logic    ops_load;
		logic    mac_clear;
		logic    mac_mul;
		mac_op_t mac_sel;
		logic    mac_acc;
		logic    out_load;
	} thi_cmd_t;

endpackage

FILE: src/thi_div.sv
// Iterative floor divider of a signed numerator by an unsigned cell size.
// Depends on thi_pkg; two quotient bits per step, DIV_STEPS steps per division.
module thi_div import thi_pkg::*; (
	input  logic                    clk,
	input  logic                    load,
	input  logic                    step,
	input  logic signed [NUM_W-1:0] num,
	input  logic [CS_W-1:0]         den,
	output logic signed [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] q_q;
	logic [CS_W-1:0]  r_q;
	logic             neg_q;
	logic [NUM_W-1:0] q_d;
	logic [CS_W-1:0]  r_d;
	logic [CS_W:0]    trial;
	logic [QUO_W-1:0] mag_up;

	// Two restoring subtract steps on the narrow remainder.
	always_comb begin
		q_d   = q_q;
		r_d   = r_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r_d, q_d[NUM_W-1]};
			q_d   = {q_d[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				r_d    = CS_W'(trial - {1'b0, den});
				q_d[0] = 1'b1;
			end else begin
				r_d = trial[CS_W-1:0];
			end
		end
	end

	// The magnitude shifts through q_q while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= num[NUM_W-1];
			q_q   <= num[NUM_W-1] ? (~$unsigned(num) + 1'b1) : $unsigned(num);
			r_q   <= '0;
		end else if (step) begin
			q_q <= q_d;
			r_q <= r_d;
		end
	end

	// A negative quotient with a remainder rounds one further down.
	assign mag_up = {1'b0, q_q} + QUO_W'(r_q != '0);
	assign quo    = neg_q ? -$signed(mag_up) : $signed({1'b0, q_q});

endmodule

FILE: src/thi_ctrl.sv
// Sequencer of the terrain height interpolator: state machine, step counter,
// output valid flag. Depends on thi_pkg; drives the datapath by a thi_cmd_t.
module thi_ctrl import thi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     cmd,
	input  logic     out_stall,
	output logic     in_stall,
	output logic     out_valid,
	output thi_cmd_t ctl
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIV  = 9'b000000010,
		ST_POST = 9'b000000100,
		ST_CELL = 9'b000001000,
		ST_ADDR = 9'b000010000,
		ST_READ = 9'b000100000,
		ST_OPS  = 9'b001000000,
		ST_MAC  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] cnt_m1;
	logic             out_valid_q;
	logic             accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cnt_m1    = cnt_q - 1'b1;
	assign out_valid = out_valid_q;

	// Next state, counter and datapath commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_QUERY) begin
						ctl.div_load = 1'b1;
						cnt_d        = '0;
						state_d      = ST_DIV;
					end else begin
						ctl.mem_wr = 1'b1;
					end
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = ST_POST;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_POST: begin
				ctl.px_load = 1'b1;
				state_d     = ST_CELL;
			end
			ST_CELL: begin
				ctl.cell_load = 1'b1;
				state_d       = ST_ADDR;
			end
			ST_ADDR: begin
				ctl.addr_load = 1'b1;
				cnt_d         = '0;
				state_d       = ST_READ;
			end
			ST_READ: begin
				// Address of corner n goes out in step n; its data lands in rd_q and is captured from there.
				ctl.rd_en   = (cnt_q < READ_LAST);
				ctl.rd_sel  = corner_t'(cnt_q[1:0]);
				ctl.cap_en  = (cnt_q != '0);
				ctl.cap_sel = corner_t'(cnt_m1[1:0]);
				if (cnt_q == READ_LAST) begin
					cnt_d   = '0;
					state_d = ST_OPS;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_OPS: begin
				ctl.ops_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MAC;
			end
			ST_MAC: begin
				// The product of each step is registered in prod_q and accumulated from there.
				ctl.mac_clear = (cnt_q == '0);
				ctl.mac_mul   = (cnt_q < MAC_LAST);
				ctl.mac_sel   = mac_op_t'(cnt_q[1:0]);
				ctl.mac_acc   = (cnt_q != '0);
				if (cnt_q == MAC_LAST) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/thi_datapath.sv
// Datapath of the terrain height interpolator: height memory, dividers,
// cell clamp, corner fetch and multiply-accumulate. Depends on thi_pkg, thi_div.
module thi_datapath import thi_pkg::*; (
	input  logic                     clk,
	input  thi_cmd_t                 ctl,
	input  logic [DIM_W-1:0]         grid_cols,
	input  logic [DIM_W-1:0]         grid_rows,
	input  logic [CS_W-1:0]          cell_size,
	input  logic [ADDR_W-1:0]        vertex_index,
	input  logic signed [HGT_W-1:0]  height_in,
	input  logic signed [POS_W-1:0]  x_pos,
	input  logic signed [POS_W-1:0]  z_pos,
	output logic signed [OUT_W-1:0]  height_out,
	output logic [COORD_W-1:0]       cell_col,
	output logic [COORD_W-1:0]       cell_row
);

	localparam int CX_W = QUO_W - FRAC_BITS;
	localparam logic signed [DLT_W-1:0] ONE_D   = DLT_W'(ONE);
	localparam logic signed [DLT_W:0]   ONE_SUM = (DLT_W + 1)'(ONE);
	localparam logic signed [ACC_W-1:0] HALF_A  = ACC_W'(ONE / 2);

	logic [HGT_W-1:0] mem [0:(1 << ADDR_W)-1];
	logic [HGT_W-1:0] rd_q;

	logic [DIM_W-1:0]             cols_eff, rows_eff;
	logic [CS_W-1:0]              cs_eff;
	logic [DIM_W-1:0]             cols_m1, rows_m1;
	logic [DIM_W-1:0]             cols_m2, rows_m2;
	logic [2*COORD_W-1:0]         ext_x, ext_z;
	logic signed [NUM_W-1:0]      hx, hz, nx, nz;
	logic signed [QUO_W-1:0]      qx, qz;
	logic signed [QUO_W-1:0]      px_q, pz_q;
	logic signed [CX_W-1:0]       cx, cz;
	logic [COORD_W-1:0]           col_d, row_d;
	logic [COORD_W-1:0]           col_q, row_q;
	logic signed [DLT_W-1:0]      dx_q, dz_q;
	logic [COORD_W+DIM_W-1:0]     rb_full;
	logic [ADDR_W-1:0]            rowbase_q;
	logic signed [DLT_W:0]        tri_sum;
	logic                         upper_q;
	logic [ADDR_W:0]              addr_sum;
	logic signed [HGT_W-1:0]      ha_q, hb_q, hc_q, hd_q;
	logic signed [COEF_W-1:0]     coef1_q, coef2_q;
	logic signed [DLT_W-1:0]      m1_q, m2_q;
	logic signed [HGT_W-1:0]      base_q;
	logic signed [COEF_W-1:0]     coef;
	logic signed [DLT_W-1:0]      mval;
	logic signed [HALF_W-1:0]     half;
	logic signed [PROD_W-1:0]     prod, prod_q;
	logic                         prod_hi_q;
	logic signed [ACC_W-1:0]      acc_q, addend, rsum, hfl;
	logic signed [OUT_W-1:0]      hsat;
	logic signed [OUT_W-1:0]      height_out_q;
	logic [COORD_W-1:0]           cell_col_q, cell_row_q;

	// Register values outside their meant range act as the nearest legal one.
	always_comb begin
		cols_eff = (grid_cols < DIM_MIN) ? DIM_MIN : ((grid_cols > DIM_MAX) ? DIM_MAX : grid_cols);
		rows_eff = (grid_rows < DIM_MIN) ? DIM_MIN : ((grid_rows > DIM_MAX) ? DIM_MAX : grid_rows);
		cs_eff   = (cell_size == '0) ? CS_W'(1) : cell_size;
		cols_m1  = cols_eff - 1'b1;
		rows_m1  = rows_eff - 1'b1;
		cols_m2  = cols_eff - DIM_W'(2);
		rows_m2  = rows_eff - DIM_W'(2);
	end

	// Half grid extent in world units, then the shifted position.
	assign ext_x = cols_m1[COORD_W-1:0] * cs_eff;
	assign ext_z = rows_m1[COORD_W-1:0] * cs_eff;
	assign hx = $signed({{(NUM_W - 2*COORD_W - FRAC_BITS + 1){1'b0}}, ext_x,
		{(FRAC_BITS - 1){1'b0}}});
	assign hz = $signed({{(NUM_W - 2*COORD_W - FRAC_BITS + 1){1'b0}}, ext_z,
		{(FRAC_BITS - 1){1'b0}}});
	assign nx = hx + {{(NUM_W - POS_W){x_pos[POS_W-1]}}, x_pos};
	assign nz = hz - {{(NUM_W - POS_W){z_pos[POS_W-1]}}, z_pos};

	thi_div u_div_x (
		.clk  (clk),
		.load (ctl.div_load),
		.step (ctl.div_step),
		.num  (nx),
		.den  (cs_eff),
		.quo  (qx)
	);

	thi_div u_div_z (
		.clk  (clk),
		.load (ctl.div_load),
		.step (ctl.div_step),
		.num  (nz),
		.den  (cs_eff),
		.quo  (qz)
	);

	// Floor to a cell and clamp it into the grid.
	always_comb begin
		cx = px_q[QUO_W-1:FRAC_BITS];
		cz = pz_q[QUO_W-1:FRAC_BITS];
		if (cx < 0) begin
			col_d = '0;
		end else if (cx > $signed({{(CX_W - DIM_W){1'b0}}, cols_m2})) begin
			col_d = cols_m2[COORD_W-1:0];
		end else begin
			col_d = cx[COORD_W-1:0];
		end
		if (cz < 0) begin
			row_d = '0;
		end else if (cz > $signed({{(CX_W - DIM_W){1'b0}}, rows_m2})) begin
			row_d = rows_m2[COORD_W-1:0];
		end else begin
			row_d = cz[COORD_W-1:0];
		end
	end

	assign rb_full = row_q * cols_eff;
	assign tri_sum = {dx_q[DLT_W-1], dx_q} + {dz_q[DLT_W-1], dz_q};

	// Corner addresses relative to the row base of the cell.
	always_comb begin
		unique case (ctl.rd_sel)
			CORNER_A: addr_sum = {1'b0, rowbase_q} + (ADDR_W + 1)'(col_q);
			CORNER_B: addr_sum = {1'b0, rowbase_q} + (ADDR_W + 1)'(col_q) + 1'b1;
			CORNER_C: addr_sum = {1'b0, rowbase_q} + (ADDR_W + 1)'(cols_eff)
				+ (ADDR_W + 1)'(col_q);
			CORNER_D: addr_sum = {1'b0, rowbase_q} + (ADDR_W + 1)'(cols_eff)
				+ (ADDR_W + 1)'(col_q) + 1'b1;
			default:  addr_sum = '0;
		endcase
	end

	// Height memory: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[vertex_index] <= height_in;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[addr_sum[ADDR_W-1:0]];
		end
	end

	// Operand selection for one partial product.
	always_comb begin
		unique case (ctl.mac_sel)
			OP_C1_LO, OP_C1_HI: begin
				coef = coef1_q;
				mval = m1_q;
			end
			default: begin
				coef = coef2_q;
				mval = m2_q;
			end
		endcase
		if (ctl.mac_sel == OP_C1_HI || ctl.mac_sel == OP_C2_HI) begin
			half = {mval[DLT_W-1], mval[DLT_W-1:SPLIT]};
		end else begin
			half = $signed({1'b0, mval[SPLIT-1:0]});
		end
		prod = coef * half;
		if (prod_hi_q) begin
			addend = {{(ACC_W - PROD_W - SPLIT){prod_q[PROD_W-1]}}, prod_q, {SPLIT{1'b0}}};
		end else begin
			addend = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
		end
	end

	// Round half up, floor to integer steps and saturate.
	always_comb begin
		rsum = acc_q + HALF_A;
		hfl  = rsum >>> FRAC_BITS;
		if (hfl[ACC_W-1:OUT_W-1] == {(ACC_W - OUT_W + 1){hfl[ACC_W-1]}}) begin
			hsat = hfl[OUT_W-1:0];
		end else if (hfl[ACC_W-1]) begin
			hsat = {1'b1, {(OUT_W - 1){1'b0}}};
		end else begin
			hsat = {1'b0, {(OUT_W - 1){1'b1}}};
		end
	end

	// Working registers, loaded step by step under sequencer control.
	always_ff @(posedge clk) begin
		if (ctl.px_load) begin
			px_q <= qx;
			pz_q <= qz;
		end
		if (ctl.cell_load) begin
			col_q <= col_d;
			row_q <= row_d;
			dx_q  <= {px_q[QUO_W-1], px_q}
				- $signed({{(DLT_W - COORD_W - FRAC_BITS){1'b0}}, col_d, {FRAC_BITS{1'b0}}});
			dz_q  <= {pz_q[QUO_W-1], pz_q}
				- $signed({{(DLT_W - COORD_W - FRAC_BITS){1'b0}}, row_d, {FRAC_BITS{1'b0}}});
		end
		if (ctl.addr_load) begin
			rowbase_q <= rb_full[ADDR_W-1:0];
			upper_q   <= (tri_sum < ONE_SUM);
		end
		if (ctl.cap_en) begin
			unique case (ctl.cap_sel)
				CORNER_A: ha_q <= rd_q;
				CORNER_B: hb_q <= rd_q;
				CORNER_C: hc_q <= rd_q;
				CORNER_D: hd_q <= rd_q;
				default:  ha_q <= rd_q;
			endcase
		end
		if (ctl.ops_load) begin
			if (upper_q) begin
				coef1_q <= {hb_q[HGT_W-1], hb_q} - {ha_q[HGT_W-1], ha_q};
				coef2_q <= {hc_q[HGT_W-1], hc_q} - {ha_q[HGT_W-1], ha_q};
				m1_q    <= dx_q;
				m2_q    <= dz_q;
				base_q  <= ha_q;
			end else begin
				coef1_q <= {hc_q[HGT_W-1], hc_q} - {hd_q[HGT_W-1], hd_q};
				coef2_q <= {hb_q[HGT_W-1], hb_q} - {hd_q[HGT_W-1], hd_q};
				m1_q    <= ONE_D - dx_q;
				m2_q    <= ONE_D - dz_q;
				base_q  <= hd_q;
			end
		end
		if (ctl.mac_mul) begin
			prod_q    <= prod;
			prod_hi_q <= (ctl.mac_sel == OP_C1_HI || ctl.mac_sel == OP_C2_HI);
		end
		if (ctl.mac_clear) begin
			acc_q <= {{(ACC_W - HGT_W - FRAC_BITS){base_q[HGT_W-1]}}, base_q,
				{FRAC_BITS{1'b0}}};
		end else if (ctl.mac_acc) begin
			acc_q <= acc_q + addend;
		end
		if (ctl.out_load) begin
			height_out_q <= hsat;
			cell_col_q   <= col_q;
			cell_row_q   <= row_q;
		end
	end

	assign height_out = height_out_q;
	assign cell_col   = cell_col_q;
	assign cell_row   = cell_row_q;

endmodule

FILE: src/terrain_height_interpolator_top.sv
// Top level of the terrain height interpolator: configuration registers,
// sequencer and datapath. Depends on thi_pkg, thi_ctrl, thi_datapath.
//
//   channel   direction  handshake               beat
//   in        to block   in_valid / in_stall     cmd, vertex_index, height_in, x_pos, z_pos
//   out       from block out_valid / out_stall   height_out, cell_col, cell_row
//   config    to block   APB psel/penable/pready grid_cols, grid_rows, cell_size
//
// A write beat is stored in the cycle it is accepted; the next beat can follow at once.
// A query beat stalls the input until its result is loaded for output, then the next beat
// can enter. The divider runs 17 steps of two quotient bits, four corner reads share
// one memory port and four partial products share one multiplier set.
// Reset clears the sequencer, presets the config registers, leaves the memory unwritten.
// A result held by out_stall lets the next beat in; only the following result waits for it.
module terrain_height_interpolator_top import thi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [ADDR_W-1:0]       vertex_index,
	input  logic signed [HGT_W-1:0] height_in,
	input  logic signed [POS_W-1:0] x_pos,
	input  logic signed [POS_W-1:0] z_pos,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] height_out,
	output logic [COORD_W-1:0]      cell_col,
	output logic [COORD_W-1:0]      cell_row
);

	logic [DIM_W-1:0] grid_cols_q;
	logic [DIM_W-1:0] grid_rows_q;
	logic [CS_W-1:0]  cell_size_q;
	logic             cfg_wr;
	reg_idx_t         reg_idx;
	thi_cmd_t         ctl;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= COLS_RST;
			grid_rows_q <= ROWS_RST;
			cell_size_q <= CS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GRID_COLS: grid_cols_q <= pwdata[DIM_W-1:0];
				REG_GRID_ROWS: grid_rows_q <= pwdata[DIM_W-1:0];
				REG_CELL_SIZE: cell_size_q <= pwdata[CS_W-1:0];
				default: ;
			endcase
		end
	end

	// Configuration register reads.
	always_comb begin
		unique case (reg_idx)
			REG_GRID_COLS: prdata = DATA_W'(grid_cols_q);
			REG_GRID_ROWS: prdata = DATA_W'(grid_rows_q);
			REG_CELL_SIZE: prdata = DATA_W'(cell_size_q);
			default:       prdata = '0;
		endcase
	end

	thi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.ctl       (ctl)
	);

	thi_datapath u_dp (
		.clk          (clk),
		.ctl          (ctl),
		.grid_cols    (grid_cols_q),
		.grid_rows    (grid_rows_q),
		.cell_size    (cell_size_q),
		.vertex_index (vertex_index),
		.height_in    (height_in),
		.x_pos        (x_pos),
		.z_pos        (z_pos),
		.height_out   (height_out),
		.cell_col     (cell_col),
		.cell_row     (cell_row)
	);

endmodule

FILE: src/thi_checker.sv
// Port-level checks of the terrain height interpolator, bound to the top level.
// Depends on thi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module thi_checker import thi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    cmd,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] height_out,
	input logic [COORD_W-1:0]      cell_col,
	input logic [COORD_W-1:0]      cell_row
);

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(height_out) && $stable(cell_col) && $stable(cell_row), "stalled result changed")

	// A query occupies the block; a height write does not.
	`ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && cmd == CMD_QUERY, in_stall, "query accepted without going busy")
	`ASSERT_NEXT(a_write_free, clk, arst_n, in_valid && !in_stall && cmd == CMD_WRITE, !in_stall, "height write blocked the input")

	// A cell is always one whose far corner lies in the grid.
	`ASSERT_IMPLIES(a_cell_range, clk, arst_n, out_valid, cell_col != '1 && cell_row != '1, "cell outside the grid")

endmodule

bind terrain_height_interpolator_top thi_checker u_thi_checker (.*);

FILE: bench/terrain_height_interpolator_top_test.sv
// Self-checking bench for terrain_height_interpolator_top: writes each corner before a query
// first reads it, runs directed and random beats and checks results with a built-in predictor.
// Depends on thi_pkg and the RTL of the terrain height interpolator only.
module terrain_height_interpolator_top_test;
	import thi_pkg::*;

	localparam int VERTEX_COUNT = 1 << ADDR_W;
	localparam int IDLE_PERCENT = 34;
	localparam int SETTLE_CYCLES = 40;
	localparam int ITEMS_PER_PHASE = 36;
	localparam int PHASE_COUNT = 8;
	// Half of the grid extent at the reset setting, in world units with fraction bits.
	localparam int HALF_SPAN = 326400;
	// Byte address one past the last register; writes there must be ignored.
	localparam logic [PADDR_W-1:0] SPARE_REG_ADDR = PADDR_W'(12);

	// Register settings of phases 1 to 5; the later phases pick random settings.
	localparam logic [DIM_W-1:0] PHASE_COLS [1:5] = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd17};
	localparam logic [DIM_W-1:0] PHASE_ROWS [1:5] = '{9'd2, 9'd256, 9'd1, 9'd300, 9'd5};
	localparam logic [CS_W-1:0]  PHASE_CELL [1:5] = '{8'd1, 8'd255, 8'd0, 8'd255, 8'd3};

	// One input beat, with an optional typed-in result.
	typedef struct packed {
		cmd_t               cmd;
		logic [ADDR_W-1:0]  vertex;
		logic [HGT_W-1:0]   height;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   z;
		logic               typed;
		logic [OUT_W-1:0]   want_height;
		logic [COORD_W-1:0] want_col;
		logic [COORD_W-1:0] want_row;
	} stim_row_t;

	typedef struct packed {
		logic [OUT_W-1:0]   height;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} terrain_result_t;

	typedef logic [3:0][ADDR_W-1:0] corner_list_t;

	// Directed beats at the reset setting: corner extremes, both triangles and the diagonal.
	localparam int DIRECTED_COUNT = 21;
	localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
		'{CMD_WRITE, 16'd0,     24'h800000, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd1,     24'h800000, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd256,   24'h800000, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd257,   24'h800000, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'h80000000, 32'h7FFFFFFF,
			1'b1, 32'hFF800000, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd65278, 24'h7FFFFF, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd65279, 24'h7FFFFF, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd65534, 24'h7FFFFF, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd65535, 24'h7FFFFF, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'h7FFFFFFF, 32'h80000000,
			1'b1, 32'h007FFFFF, 8'd254, 8'd254},
		'{CMD_WRITE, 16'd0,     24'h000100, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'(-HALF_SPAN), 32'(HALF_SPAN),
			1'b1, 32'h00000100, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd1,     24'h7FFFFF, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'h80000000, 32'(HALF_SPAN),
			1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_WRITE, 16'd65535, 24'h800000, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'h7FFFFFFF, 32'h80000000,
			1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'(-HALF_SPAN + 2000), 32'(HALF_SPAN - 2000),
			1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'(-HALF_SPAN + 1280), 32'(HALF_SPAN - 1280),
			1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'(-HALF_SPAN + 1270), 32'(HALF_SPAN - 1280),
			1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'(-HALF_SPAN - 7), 32'(HALF_SPAN + 3),
			1'b0, 32'd0, 8'd0, 8'd0},
		'{CMD_QUERY, 16'd0, 24'd0, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 8'd0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic                    cmd;
	logic [ADDR_W-1:0]       vertex_index;
	logic signed [HGT_W-1:0] height_in;
	logic signed [POS_W-1:0] x_pos;
	logic signed [POS_W-1:0] z_pos;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] height_out;
	logic [COORD_W-1:0]      cell_col;
	logic [COORD_W-1:0]      cell_row;

	// Predictor state: the height grid, which entries hold a height, and the register copies.
	logic signed [HGT_W-1:0] vertex_heights [0:VERTEX_COUNT-1];
	bit                      vertex_written [0:VERTEX_COUNT-1];
	logic [DIM_W-1:0]        cfg_cols;
	logic [DIM_W-1:0]        cfg_rows;
	logic [CS_W-1:0]         cfg_cell;

	terrain_result_t pending_heights [$];
	terrain_result_t next_due;
	int              fault_count;
	logic            calm_phase;

	terrain_height_interpolator_top dut (.*);

	// Clock with a period of two time units.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("terrain_height_interpolator_top_test NOT OK");
		$finish;
	end

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	// Grid dimension as the block uses it, with out-of-range settings pulled into 2..256.
	function automatic int grid_span(logic [DIM_W-1:0] v);
		return int'(v < DIM_MIN ? DIM_MIN : (v > DIM_MAX ? DIM_MAX : v));
	endfunction

	// Random height with the extremes mixed in.
	function automatic logic [HGT_W-1:0] random_height();
		if ($urandom_range(15) == 0)
			return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
		return HGT_W'($urandom);
	endfunction

	// Interpolated height, cell column and cell row for a query at world x, z.
	function automatic terrain_result_t interpolate_height(logic [POS_W-1:0] xq,
			logic [POS_W-1:0] zq);
		terrain_result_t r;
		longint cols, rows, cs, hx, hz, px, pz, cx, cz, dx, dz, a, b, c, d, s, h;
		cols = grid_span(cfg_cols);
		rows = grid_span(cfg_rows);
		cs = (cfg_cell == '0) ? 1 : longint'(cfg_cell);
		hx = (cols - 1) * cs * ONE / 2;
		hz = (rows - 1) * cs * ONE / 2;
		px = floor_div(hx + longint'($signed(xq)), cs);
		pz = floor_div(hz - longint'($signed(zq)), cs);

		// Floor to a cell and clamp it into the grid; offsets stay unbounded.
		cx = floor_div(px, ONE);
		cz = floor_div(pz, ONE);
		if (cx < 0) cx = 0;
		if (cz < 0) cz = 0;
		if (cx > cols - 2) cx = cols - 2;
		if (cz > rows - 2) cz = rows - 2;
		dx = px - cx * ONE;
		dz = pz - cz * ONE;

		a = vertex_heights[cz * cols + cx];
		b = vertex_heights[cz * cols + cx + 1];
		c = vertex_heights[(cz + 1) * cols + cx];
		d = vertex_heights[(cz + 1) * cols + cx + 1];

		// Upper triangle below the diagonal, lower triangle on and past it.
		if (dx + dz < ONE)
			s = a * ONE + (b - a) * dx + (c - a) * dz;
		else
			s = d * ONE + (c - d) * (ONE - dx) + (b - d) * (ONE - dz);

		// Round half up, then saturate to 32 bits.
		h = floor_div(s + ONE / 2, ONE);
		if (h > 64'sd2147483647) h = 64'sd2147483647;
		if (h < -64'sd2147483648) h = -64'sd2147483648;
		r.height = h[OUT_W-1:0];
		r.col = cx[COORD_W-1:0];
		r.row = cz[COORD_W-1:0];
		return r;
	endfunction

	// Store entries of the four corners that a query at world x, z reads.
	function automatic corner_list_t query_corners(logic [POS_W-1:0] xq, logic [POS_W-1:0] zq);
		corner_list_t idx;
		longint cols, rows, cs, hx, hz, cx, cz;
		cols = grid_span(cfg_cols);
		rows = grid_span(cfg_rows);
		cs = (cfg_cell == '0) ? 1 : longint'(cfg_cell);
		hx = (cols - 1) * cs * ONE / 2;
		hz = (rows - 1) * cs * ONE / 2;
		cx = floor_div(floor_div(hx + longint'($signed(xq)), cs), ONE);
		cz = floor_div(floor_div(hz - longint'($signed(zq)), cs), ONE);
		if (cx < 0) cx = 0;
		if (cz < 0) cz = 0;
		if (cx > cols - 2) cx = cols - 2;
		if (cz > rows - 2) cz = rows - 2;
		idx[0] = ADDR_W'(cz * cols + cx);
		idx[1] = ADDR_W'(cz * cols + cx + 1);
		idx[2] = ADDR_W'((cz + 1) * cols + cx);
		idx[3] = ADDR_W'((cz + 1) * cols + cx + 1);
		return idx;
	endfunction

	// Random beat shaped by the current grid: mostly in-grid writes and near-grid queries.
	function automatic stim_row_t random_row();
		stim_row_t r;
		int cols, rows, cs, px, pz;
		longint hx, hz;
		cols = grid_span(cfg_cols);
		rows = grid_span(cfg_rows);
		cs = (cfg_cell == '0) ? 1 : int'(cfg_cell);
		hx = longint'(cols - 1) * cs * ONE / 2;
		hz = longint'(rows - 1) * cs * ONE / 2;
		r = '0;
		r.vertex = ADDR_W'($urandom);
		r.height = HGT_W'($urandom);
		r.x = $urandom;
		r.z = $urandom;
		if ($urandom_range(99) < 45) begin
			r.cmd = CMD_WRITE;
			if ($urandom_range(99) < 75)
				r.vertex = ADDR_W'(int'($urandom_range(rows - 1)) * cols
					+ int'($urandom_range(cols - 1)));
			if ($urandom_range(9) == 0)
				r.height = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
		end else begin
			r.cmd = CMD_QUERY;
			if ($urandom_range(99) < 88) begin
				px = int'($urandom_range((cols + 2) * ONE)) - ONE;
				pz = int'($urandom_range((rows + 2) * ONE)) - ONE;
				r.x = POS_W'(longint'(px) * cs - hx + longint'($urandom_range(cs - 1)));
				r.z = POS_W'(hz - longint'(pz) * cs - longint'($urandom_range(cs - 1)));
			end
		end
		return r;
	endfunction

	// Offer one beat, wait for it to be taken, then update the predictor.
	task automatic drive_row(input stim_row_t r);
		while (!calm_phase && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= r.cmd;
		vertex_index <= r.vertex;
		height_in <= r.height;
		x_pos <= r.x;
		z_pos <= r.z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (r.cmd == CMD_WRITE) begin
			vertex_heights[r.vertex] = r.height;
			vertex_written[r.vertex] = 1'b1;
		end else if (r.typed)
			pending_heights.push_back('{r.want_height, r.want_col, r.want_row});
		else
			pending_heights.push_back(interpolate_height(r.x, r.z));
	endtask

	// Write each corner of a query's cell that holds no height yet, then send the beat.
	task automatic drive_item(input stim_row_t r);
		corner_list_t idx;
		stim_row_t w;
		if (r.cmd == CMD_QUERY) begin
			idx = query_corners(r.x, r.z);
			for (int k = 0; k < 4; k++) begin
				if (!vertex_written[idx[k]]) begin
					w = '0;
					w.cmd = CMD_WRITE;
					w.vertex = idx[k];
					w.height = random_height();
					drive_row(w);
				end
			end
		end
		drive_row(r);
	endtask

	// APB write: setup cycle, then the access cycle.
	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Set all three registers; unused upper data bits carry noise.
	task automatic program_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
			input logic [CS_W-1:0] cs);
		write_register(PADDR_W'(4 * int'(REG_GRID_COLS)), ($urandom & 32'hFFFFFE00) | cols);
		cfg_cols = cols;
		write_register(PADDR_W'(4 * int'(REG_GRID_ROWS)), ($urandom & 32'hFFFFFE00) | rows);
		cfg_rows = rows;
		write_register(PADDR_W'(4 * int'(REG_CELL_SIZE)), ($urandom & 32'hFFFFFF00) | cs);
		cfg_cell = cs;
		write_register(SPARE_REG_ADDR, $urandom);
	endtask

	// Wait for every outstanding result, then let the block settle.
	task automatic wait_idle();
		while (pending_heights.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random receiver stalls, off in calm phases.
	always @(posedge clk)
		out_stall <= !calm_phase && ($urandom_range(99) < IDLE_PERCENT);

	// Compare each result beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_heights.size() == 0) begin
				$error("result beat with no prediction: height_out %0d", height_out);
				fault_count++;
			end else begin
				next_due = pending_heights.pop_front();
				if (height_out !== next_due.height) begin
					$error("height_out expected %0d actual %0d",
						$signed(next_due.height), height_out);
					fault_count++;
				end
				if (cell_col !== next_due.col) begin
					$error("cell_col expected %0d actual %0d", next_due.col, cell_col);
					fault_count++;
				end
				if (cell_row !== next_due.row) begin
					$error("cell_row expected %0d actual %0d", next_due.row, cell_row);
					fault_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed beats, then random phases.
	initial begin
		fault_count = 0;
		arst_n <= 1'b0;
		calm_phase <= 1'b1;
		out_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_WRITE;
		vertex_index <= '0;
		height_in <= '0;
		x_pos <= '0;
		z_pos <= '0;
		cfg_cols = COLS_RST;
		cfg_rows = ROWS_RST;
		cfg_cell = CS_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase > 0) begin
				in_valid <= 1'b0;
				wait_idle();
				if (phase <= 5)
					program_grid(PHASE_COLS[phase], PHASE_ROWS[phase], PHASE_CELL[phase]);
				else
					program_grid(DIM_W'($urandom_range(2, 256)), DIM_W'($urandom_range(2, 256)),
						CS_W'($urandom_range(1, 255)));
			end
			calm_phase <= (phase == 2);
			if (phase == 0) begin
				for (int i = 0; i < DIRECTED_COUNT; i++)
					drive_item(DIRECTED_ROWS[i]);
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				drive_item(random_row());
		end

		in_valid <= 1'b0;
		wait_idle();
		if (fault_count == 0)
			$display("terrain_height_interpolator_top_test OK");
		else
			$display("terrain_height_interpolator_top_test NOT OK");
		$finish;
	end

endmodule
